// ===== rtl/core/assert_macros.svh =====
// Assertion macros for the deque RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property that must hold on every clock edge out of reset.
`define ASSERT_ALWAYS(label, clk, rst_n, prop) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
	else $error("assertion failed");

// Same-cycle implication.
`define ASSERT_IMPL(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
	else $error("assertion failed");

// Next-cycle implication.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
	else $error("assertion failed");

`endif

// ===== rtl/core/deq_pkg.sv =====
// Shared types and constants of the double-ended queue.
`default_nettype none

package deq_pkg;

	// Default configuration and fixed port widths
	localparam int DEPTH_DEF      = 16;
	localparam int DATA_WIDTH_DEF = 32;
	localparam int VALUE_W        = 32;
	localparam int REQ_W          = 3;
	localparam int STATUS_W       = 2;
	localparam int COUNT_W        = 5;

	// Request codes carried by req_type
	typedef enum logic [REQ_W-1:0] {
		REQ_PUSH_HEAD = 3'd0,
		REQ_PUSH_TAIL = 3'd1,
		REQ_POP_HEAD  = 3'd2,
		REQ_POP_TAIL  = 3'd3,
		REQ_PEEK_HEAD = 3'd4,
		REQ_PEEK_TAIL = 3'd5
	} req_t;

	// Result status codes
	typedef enum logic [STATUS_W-1:0] {
		ST_OK    = 2'd0,
		ST_EMPTY = 2'd1,
		ST_FULL  = 2'd2
	} status_t;

	// Datapath operations issued by the controller
	typedef enum logic [2:0] {
		OP_NOP        = 3'd0,
		OP_PUSH_FIRST = 3'd1,
		OP_PUSH_HEAD  = 3'd2,
		OP_PUSH_TAIL  = 3'd3,
		OP_POP_HEAD   = 3'd4,
		OP_POP_TAIL   = 3'd5,
		OP_PEEK_HEAD  = 3'd6,
		OP_PEEK_TAIL  = 3'd7
	} op_t;

	// Controller to datapath commands
	typedef struct packed {
		logic    cap;
		op_t     op;
		logic    load;
		status_t code;
		logic    use_value;
	} cmd_t;

	// Datapath to controller status
	typedef struct packed {
		logic empty;
		logic full;
	} stat_t;

endpackage

`default_nettype wire

// ===== rtl/core/deq_ctrl.sv =====
// Request sequencer of the double-ended queue.
`default_nettype none

module deq_ctrl (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       in_valid,
	output logic                            in_stall,
	input  wire logic [deq_pkg::REQ_W-1:0]  req_type,
	output logic                            out_valid,
	input  wire logic                       out_stall,
	input  wire deq_pkg::stat_t             stat,
	output deq_pkg::cmd_t                   cmd
);

	typedef enum logic [1:0] {
		S_IDLE,
		S_EXEC,
		S_LOAD
	} state_t;

	state_t            state_q;
	deq_pkg::req_t     req_q;
	deq_pkg::status_t  code_q;
	logic              use_q;
	logic              out_valid_q;

	deq_pkg::op_t      op_d;
	deq_pkg::status_t  code_d;
	logic              use_d;
	logic              slot_free;

	// Decode the held request against the current fill state
	always_comb begin
		op_d   = deq_pkg::OP_NOP;
		code_d = deq_pkg::ST_OK;
		use_d  = 1'b0;
		case (req_q)
			deq_pkg::REQ_PUSH_HEAD: begin
				if (stat.full)
					code_d = deq_pkg::ST_FULL;
				else if (stat.empty)
					op_d = deq_pkg::OP_PUSH_FIRST;
				else
					op_d = deq_pkg::OP_PUSH_HEAD;
			end
			deq_pkg::REQ_PUSH_TAIL: begin
				if (stat.full)
					code_d = deq_pkg::ST_FULL;
				else if (stat.empty)
					op_d = deq_pkg::OP_PUSH_FIRST;
				else
					op_d = deq_pkg::OP_PUSH_TAIL;
			end
			deq_pkg::REQ_POP_HEAD: begin
				if (stat.empty) begin
					code_d = deq_pkg::ST_EMPTY;
				end else begin
					op_d  = deq_pkg::OP_POP_HEAD;
					use_d = 1'b1;
				end
			end
			deq_pkg::REQ_POP_TAIL: begin
				if (stat.empty) begin
					code_d = deq_pkg::ST_EMPTY;
				end else begin
					op_d  = deq_pkg::OP_POP_TAIL;
					use_d = 1'b1;
				end
			end
			deq_pkg::REQ_PEEK_HEAD: begin
				if (stat.empty) begin
					code_d = deq_pkg::ST_EMPTY;
				end else begin
					op_d  = deq_pkg::OP_PEEK_HEAD;
					use_d = 1'b1;
				end
			end
			deq_pkg::REQ_PEEK_TAIL: begin
				if (stat.empty) begin
					code_d = deq_pkg::ST_EMPTY;
				end else begin
					op_d  = deq_pkg::OP_PEEK_TAIL;
					use_d = 1'b1;
				end
			end
			default: begin
				// unknown codes are ignored and report ok
			end
		endcase
	end

	// Output register can take a new item when empty or being drained
	assign slot_free = !out_valid_q || !out_stall;

	// Commands to the datapath
	always_comb begin
		cmd.cap       = (state_q == S_IDLE) && in_valid;
		cmd.op        = (state_q == S_EXEC) ? op_d : deq_pkg::OP_NOP;
		cmd.load      = (state_q == S_LOAD) && slot_free;
		cmd.code      = code_q;
		cmd.use_value = use_q;
	end

	assign in_stall  = (state_q != S_IDLE);
	assign out_valid = out_valid_q;

	// State and registered outputs
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			req_q       <= deq_pkg::REQ_PUSH_HEAD;
			code_q      <= deq_pkg::ST_OK;
			use_q       <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			// result valid: set on load, cleared once the item is taken
			if (state_q == S_LOAD && slot_free)
				out_valid_q <= 1'b1;
			else if (!out_stall)
				out_valid_q <= 1'b0;
			case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						req_q   <= deq_pkg::req_t'(req_type);
						state_q <= S_EXEC;
					end
				end
				S_EXEC: begin
					code_q  <= code_d;
					use_q   <= use_d;
					state_q <= S_LOAD;
				end
				S_LOAD: begin
					if (slot_free)
						state_q <= S_IDLE;
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

endmodule

`default_nettype wire

// ===== rtl/core/deq_datapath.sv =====
// Ring store, end pointers, fill count and result register of the deque.
`default_nettype none
`include "assert_macros.svh"

module deq_datapath #(
	parameter int DEPTH      = deq_pkg::DEPTH_DEF,
	parameter int DATA_WIDTH = deq_pkg::DATA_WIDTH_DEF
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic [deq_pkg::VALUE_W-1:0]   item_value,
	input  wire deq_pkg::cmd_t                 cmd,
	output deq_pkg::stat_t                     stat,
	output logic [deq_pkg::VALUE_W-1:0]        out_value,
	output logic [deq_pkg::STATUS_W-1:0]       status,
	output logic [deq_pkg::COUNT_W-1:0]        count
);

	localparam int AW = $clog2(DEPTH);
	localparam int CW = $clog2(DEPTH + 1);

	logic [DATA_WIDTH-1:0]          mem_q [DEPTH];
	logic [DATA_WIDTH-1:0]          word_q;
	logic [DATA_WIDTH-1:0]          rdata_q;
	logic [AW-1:0]                  head_q;
	logic [AW-1:0]                  tail_q;
	logic [CW-1:0]                  occ_q;
	logic [deq_pkg::VALUE_W-1:0]    out_value_q;
	logic [deq_pkg::STATUS_W-1:0]   status_q;
	logic [deq_pkg::COUNT_W-1:0]    count_q;

	logic [AW-1:0]                  head_up;
	logic [AW-1:0]                  head_dn;
	logic [AW-1:0]                  tail_up;
	logic [AW-1:0]                  tail_dn;
	logic                           wr_en;
	logic [AW-1:0]                  wr_addr;
	logic                           rd_en;
	logic [AW-1:0]                  rd_addr;
	logic                           last;
	logic                           pop_last;

	// Ring neighbors of both pointers
	assign head_up = (head_q == AW'(DEPTH - 1)) ? '0 : head_q + AW'(1);
	assign head_dn = (head_q == '0) ? AW'(DEPTH - 1) : head_q - AW'(1);
	assign tail_up = (tail_q == AW'(DEPTH - 1)) ? '0 : tail_q + AW'(1);
	assign tail_dn = (tail_q == '0) ? AW'(DEPTH - 1) : tail_q - AW'(1);

	assign last       = (occ_q == CW'(1));
	assign stat.empty = (occ_q == '0);
	assign stat.full  = (occ_q == CW'(DEPTH));
	assign pop_last   = (cmd.op == deq_pkg::OP_POP_HEAD || cmd.op == deq_pkg::OP_POP_TAIL)
		&& last;

	// Store port selection
	always_comb begin
		wr_en   = 1'b0;
		wr_addr = head_q;
		rd_en   = 1'b0;
		rd_addr = head_q;
		case (cmd.op)
			deq_pkg::OP_PUSH_FIRST: begin
				wr_en = 1'b1;
			end
			deq_pkg::OP_PUSH_HEAD: begin
				wr_en   = 1'b1;
				wr_addr = head_up;
			end
			deq_pkg::OP_PUSH_TAIL: begin
				wr_en   = 1'b1;
				wr_addr = tail_dn;
			end
			deq_pkg::OP_POP_HEAD, deq_pkg::OP_PEEK_HEAD: begin
				rd_en = 1'b1;
			end
			deq_pkg::OP_POP_TAIL, deq_pkg::OP_PEEK_TAIL: begin
				rd_en   = 1'b1;
				rd_addr = tail_q;
			end
			default: begin
			end
		endcase
	end

	// Ring store with registered read
	always_ff @(posedge clk) begin
		if (wr_en)
			mem_q[wr_addr] <= word_q;
		if (rd_en)
			rdata_q <= mem_q[rd_addr];
	end

	// Captured push word
	always_ff @(posedge clk) begin
		if (cmd.cap)
			word_q <= DATA_WIDTH'(item_value);
	end

	// End pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q <= '0;
			tail_q <= '0;
			occ_q  <= '0;
		end else begin
			case (cmd.op)
				deq_pkg::OP_PUSH_FIRST: begin
					tail_q <= head_q;
					occ_q  <= CW'(1);
				end
				deq_pkg::OP_PUSH_HEAD: begin
					head_q <= head_up;
					occ_q  <= occ_q + CW'(1);
				end
				deq_pkg::OP_PUSH_TAIL: begin
					tail_q <= tail_dn;
					occ_q  <= occ_q + CW'(1);
				end
				deq_pkg::OP_POP_HEAD: begin
					// popping the last word parks both pointers on its slot
					if (last)
						tail_q <= head_q;
					else
						head_q <= head_dn;
					occ_q <= occ_q - CW'(1);
				end
				deq_pkg::OP_POP_TAIL: begin
					if (last)
						head_q <= tail_q;
					else
						tail_q <= tail_up;
					occ_q <= occ_q - CW'(1);
				end
				default: begin
				end
			endcase
		end
	end

	// Result register
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			out_value_q <= cmd.use_value ? deq_pkg::VALUE_W'(rdata_q) : '0;
			status_q    <= cmd.code;
			count_q     <= deq_pkg::COUNT_W'(occ_q);
		end
	end

	assign out_value = out_value_q;
	assign status    = status_q;
	assign count     = count_q;

	`ASSERT_ALWAYS(a_occ_bound, clk, arst_n, occ_q <= CW'(DEPTH))
	`ASSERT_IMPL(a_no_write_full, clk, arst_n, wr_en, !stat.full)
	`ASSERT_IMPL(a_no_read_empty, clk, arst_n, rd_en, !stat.empty)
	`ASSERT_NEXT(a_last_pop_parks, clk, arst_n, pop_last, head_q == tail_q && stat.empty)

endmodule

`default_nettype wire

// ===== rtl/core/double_ended_queue_unit.sv =====
// Top level of the double-ended queue: controller plus ring-store datapath.
// Each request passes the accept, execute and load steps of the controller around
// the registered read port of the ring store; load waits while out_stall holds the
// old result. A new item is accepted only once the result of the last is loaded.
// Reset: pointers, fill count and handshake state clear at once; the ring store
// is not cleared, and no clearing pass runs, so items are taken right after reset.
`default_nettype none

module double_ended_queue_unit #(
	parameter int DEPTH      = deq_pkg::DEPTH_DEF,
	parameter int DATA_WIDTH = deq_pkg::DATA_WIDTH_DEF
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          in_valid,
	output logic                               in_stall,
	input  wire logic [deq_pkg::REQ_W-1:0]     req_type,
	input  wire logic [deq_pkg::VALUE_W-1:0]   item_value,
	output logic                               out_valid,
	input  wire logic                          out_stall,
	output logic [deq_pkg::VALUE_W-1:0]        out_value,
	output logic [deq_pkg::STATUS_W-1:0]       status,
	output logic [deq_pkg::COUNT_W-1:0]        count
);

	deq_pkg::cmd_t  cmd;
	deq_pkg::stat_t stat;

	// Request sequencer
	deq_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.req_type  (req_type),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.stat      (stat),
		.cmd       (cmd)
	);

	// Store, pointers and result register
	deq_datapath #(
		.DEPTH      (DEPTH),
		.DATA_WIDTH (DATA_WIDTH)
	) u_datapath (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_value (item_value),
		.cmd        (cmd),
		.stat       (stat),
		.out_value  (out_value),
		.status     (status),
		.count      (count)
	);

endmodule

`default_nettype wire
